[hw/rtl/pwc_pkg.sv]
`default_nettype none

package pwc_pkg;

    localparam int MAX_IN_CH  = 16;
    localparam int MAX_OUT_CH = 16;
    localparam int DATA_WIDTH = 16;

    localparam int CH_SLOTS = 16;
    localparam int IMG_MAX  = 4096;
    localparam int PADDR_W  = 4;
    localparam int ACC_W    = 38;

    localparam int N_IN_LIM  = (MAX_IN_CH < CH_SLOTS) ? MAX_IN_CH : CH_SLOTS;
    localparam int N_OUT_LIM = (MAX_OUT_CH < CH_SLOTS) ? MAX_OUT_CH : CH_SLOTS;

    localparam logic signed [ACC_W-1:0] SAT_HI =
        ACC_W'((longint'(1) <<< (DATA_WIDTH - 1)) - longint'(1));
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    localparam logic [1:0] CMD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_BIAS   = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    localparam logic [1:0] REG_IN_CH  = 2'd0;
    localparam logic [1:0] REG_OUT_CH = 2'd1;
    localparam logic [1:0] REG_ROWS   = 2'd2;
    localparam logic [1:0] REG_COLS   = 2'd3;

    // One multiply-accumulate step handed from the sequencer to the datapath.
    typedef struct packed {
        logic       valid;
        logic [3:0] co;
        logic [3:0] ci;
        logic       first;
        logic       last;
        logic       last_pix;
        logic       last_img;
    } issue_t;

    typedef struct packed {
        logic [3:0] co;
        logic       first;
        logic       last;
        logic       last_pix;
        logic       last_img;
    } meta_t;

    typedef struct packed {
        logic               we_w;
        logic               we_b;
        logic               we_x;
        logic [7:0]         addr;
        logic [3:0]         slot;
        logic signed [15:0] data;
    } mem_wr_t;

endpackage

`default_nettype wire

[hw/rtl/pwc_seq.sv]
`default_nettype none

module pwc_seq (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            sample_acc,
    input  wire logic [4:0]      n_in,
    input  wire logic [4:0]      n_out,
    input  wire logic [24:0]     pix_total,
    input  wire logic            stall,
    output logic                 idle,
    output logic [3:0]           chan_slot,
    output pwc_pkg::issue_t      issue
);
    import pwc_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic        state_reg, state_next;
    logic [3:0]  chan_cnt_reg, chan_cnt_next;
    logic [23:0] pix_cnt_reg, pix_cnt_next;
    logic [3:0]  co_reg, co_next;
    logic [3:0]  ci_reg, ci_next;
    logic [4:0]  nin_reg, nin_next;
    logic [4:0]  nout_reg, nout_next;
    logic        img_last_reg, img_last_next;

    logic        complete;
    logic        img_last;
    logic        ci_last;
    logic        co_last;

    assign complete = !((5'(chan_cnt_reg) + 5'd1) < n_in);
    assign img_last = (25'(pix_cnt_reg) + 25'd1) >= pix_total;
    assign ci_last  = (5'(ci_reg) + 5'd1) == nin_reg;
    assign co_last  = (5'(co_reg) + 5'd1) == nout_reg;

    always_comb begin
        state_next    = state_reg;
        chan_cnt_next = chan_cnt_reg;
        pix_cnt_next  = pix_cnt_reg;
        co_next       = co_reg;
        ci_next       = ci_reg;
        nin_next      = nin_reg;
        nout_next     = nout_reg;
        img_last_next = img_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (sample_acc) begin
                    if (complete) begin
                        chan_cnt_next = 4'd0;
                        pix_cnt_next  = img_last ? 24'd0 : pix_cnt_reg + 24'd1;
                        img_last_next = img_last;
                        nin_next      = n_in;
                        nout_next     = n_out;
                        co_next       = 4'd0;
                        ci_next       = 4'd0;
                        state_next    = ST_RUN;
                    end else begin
                        chan_cnt_next = chan_cnt_reg + 4'd1;
                    end
                end
            end
            ST_RUN: begin
                if (!stall) begin
                    if (ci_last) begin
                        ci_next = 4'd0;
                        if (co_last) begin
                            state_next = ST_IDLE;
                        end else begin
                            co_next = co_reg + 4'd1;
                        end
                    end else begin
                        ci_next = ci_reg + 4'd1;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            chan_cnt_reg <= 4'd0;
            pix_cnt_reg  <= 24'd0;
            co_reg       <= 4'd0;
            ci_reg       <= 4'd0;
            nin_reg      <= 5'd1;
            nout_reg     <= 5'd1;
            img_last_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            chan_cnt_reg <= chan_cnt_next;
            pix_cnt_reg  <= pix_cnt_next;
            co_reg       <= co_next;
            ci_reg       <= ci_next;
            nin_reg      <= nin_next;
            nout_reg     <= nout_next;
            img_last_reg <= img_last_next;
        end
    end

    assign idle      = (state_reg == ST_IDLE);
    assign chan_slot = chan_cnt_reg;

    always_comb begin
        issue.valid    = (state_reg == ST_RUN);
        issue.co       = co_reg;
        issue.ci       = ci_reg;
        issue.first    = (ci_reg == 4'd0);
        issue.last     = ci_last;
        issue.last_pix = co_last;
        issue.last_img = co_last && img_last_reg;
    end

    a_run_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> ((5'(ci_reg) < nin_reg) && (5'(co_reg) < nout_reg)))
        else $error("issue indices beyond latched channel counts");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_RUN) && stall) |=>
            ((state_reg == ST_RUN) && $stable(co_reg) && $stable(ci_reg)))
        else $error("sequencer advanced while the datapath was stalled");

    a_pixel_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (sample_acc && complete) |=> ((chan_cnt_reg == 4'd0) && (state_reg == ST_RUN)))
        else $error("completed pixel did not start the multiply-accumulate run");

endmodule

`default_nettype wire

[hw/rtl/pwc_mac.sv]
`default_nettype none

module pwc_mac (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire pwc_pkg::mem_wr_t   wr,
    input  wire pwc_pkg::issue_t    issue,
    input  wire logic               m_ready,
    output logic                    m_valid,
    output logic [3:0]              m_out_channel,
    output logic signed [15:0]      m_result_value,
    output logic                    m_last_of_pixel,
    output logic                    m_last_of_image,
    output logic                    stall
);
    import pwc_pkg::*;

    logic signed [15:0] weight_mem [256];
    logic signed [15:0] bias_mem   [CH_SLOTS];
    logic signed [15:0] sample_mem [CH_SLOTS];

    // Stage 1: registered store reads.
    logic               v1_reg;
    meta_t              meta1_reg;
    logic signed [15:0] w_rd_reg;
    logic signed [15:0] x_rd_reg;
    logic signed [15:0] b_rd_reg;

    // Stage 2: product.
    logic               v2_reg;
    meta_t              meta2_reg;
    logic signed [31:0] prod_reg;
    logic signed [15:0] bias2_reg;

    // Stage 3: accumulator.
    logic                    res_v_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [3:0]              co3_reg;
    logic                    lp3_reg;
    logic                    li3_reg;

    logic                    m_valid_reg;
    logic [3:0]              m_co_reg;
    logic signed [15:0]      m_val_reg;
    logic                    m_lp_reg;
    logic                    m_li_reg;

    logic signed [ACC_W-1:0] acc_base;
    logic signed [ACC_W-1:0] rnd_sum;
    logic signed [ACC_W-1:0] rnd_q;
    logic signed [ACC_W-1:0] sat_q;
    meta_t                   issue_meta;

    // A finished sum cannot leave while the output register is still held.
    assign stall = res_v_reg && m_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (wr.we_w) begin
            weight_mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.we_b) begin
            bias_mem[wr.addr[3:0]] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.we_x) begin
            sample_mem[wr.slot] <= wr.data;
        end
    end

    always_comb begin
        issue_meta.co       = issue.co;
        issue_meta.first    = issue.first;
        issue_meta.last     = issue.last;
        issue_meta.last_pix = issue.last_pix;
        issue_meta.last_img = issue.last_img;
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            w_rd_reg  <= weight_mem[{issue.co, issue.ci}];
            x_rd_reg  <= sample_mem[issue.ci];
            b_rd_reg  <= bias_mem[issue.co];
            meta1_reg <= issue_meta;
            prod_reg  <= w_rd_reg * x_rd_reg;
            bias2_reg <= b_rd_reg;
            meta2_reg <= meta1_reg;
        end
    end

    assign acc_base = meta2_reg.first ? (ACC_W'(bias2_reg) <<< 8) : acc_reg;

    always_ff @(posedge aclk) begin
        if (!stall && v2_reg) begin
            acc_reg <= acc_base + ACC_W'(prod_reg);
            if (meta2_reg.last) begin
                co3_reg <= meta2_reg.co;
                lp3_reg <= meta2_reg.last_pix;
                li3_reg <= meta2_reg.last_img;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            res_v_reg <= 1'b0;
        end else if (!stall) begin
            v1_reg    <= issue.valid;
            v2_reg    <= v1_reg;
            res_v_reg <= v2_reg && meta2_reg.last;
        end
    end

    // Round to nearest with ties upward, then saturate to the data range.
    assign rnd_sum = acc_reg + ACC_W'(2048);
    assign rnd_q   = rnd_sum >>> 12;

    always_comb begin
        priority if (rnd_q > SAT_HI) begin
            sat_q = SAT_HI;
        end else if (rnd_q < SAT_LO) begin
            sat_q = SAT_LO;
        end else begin
            sat_q = rnd_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_v_reg && !stall) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_v_reg && !stall) begin
            m_co_reg  <= co3_reg;
            m_val_reg <= sat_q[15:0];
            m_lp_reg  <= lp3_reg;
            m_li_reg  <= li3_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_channel   = m_co_reg;
    assign m_result_value  = m_val_reg;
    assign m_last_of_pixel = m_lp_reg;
    assign m_last_of_image = m_li_reg;

endmodule

`default_nettype wire

[hw/rtl/pointwise_conv_1x1.sv]
`default_nettype none

// Weight, bias and non-final sample requests leave the block idle. The final sample of a
// pixel starts in_channels*out_channels steps of one shared multiply-accumulate unit,
// and no request is taken until the last step issues (longer while m_ready stalls).
// Each step passes the store-read, product and accumulator registers; the rounded, saturated
// sum of an output channel then enters the output register. Reset (aresetn low at a clock
// edge) clears the counters and output valid, sets all four registers to 1; stores keep X.
module pointwise_conv_1x1 (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [pwc_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_cmd,
    input  wire logic [7:0]                  s_addr,
    input  wire logic signed [15:0]          s_value,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [3:0]                       m_out_channel,
    output logic signed [15:0]               m_result_value,
    output logic                             m_last_of_pixel,
    output logic                             m_last_of_image
);
    import pwc_pkg::*;

    logic [4:0]  in_ch_reg;
    logic [4:0]  out_ch_reg;
    logic [12:0] rows_reg;
    logic [12:0] cols_reg;
    logic [24:0] pix_total;

    logic        cfg_wr;
    logic [1:0]  reg_sel;
    logic [4:0]  n_in;
    logic [4:0]  n_out;
    logic [12:0] rows_eff;
    logic [12:0] cols_eff;
    logic        in_acc;
    logic        sample_acc;
    logic        idle;
    logic [3:0]  chan_slot;
    logic        stall;
    issue_t      issue;
    mem_wr_t     wr;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[PADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_ch_reg  <= 5'd1;
            out_ch_reg <= 5'd1;
            rows_reg   <= 13'd1;
            cols_reg   <= 13'd1;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_IN_CH:  in_ch_reg  <= pwdata[4:0];
                REG_OUT_CH: out_ch_reg <= pwdata[4:0];
                REG_ROWS:   rows_reg   <= pwdata[12:0];
                REG_COLS:   cols_reg   <= pwdata[12:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_IN_CH:  prdata = 32'(in_ch_reg);
            REG_OUT_CH: prdata = 32'(out_ch_reg);
            REG_ROWS:   prdata = 32'(rows_reg);
            REG_COLS:   prdata = 32'(cols_reg);
        endcase
    end

    always_comb begin
        priority if (in_ch_reg == 5'd0) begin
            n_in = 5'd1;
        end else if (in_ch_reg > 5'(N_IN_LIM)) begin
            n_in = 5'(N_IN_LIM);
        end else begin
            n_in = in_ch_reg;
        end
        priority if (out_ch_reg == 5'd0) begin
            n_out = 5'd1;
        end else if (out_ch_reg > 5'(N_OUT_LIM)) begin
            n_out = 5'(N_OUT_LIM);
        end else begin
            n_out = out_ch_reg;
        end
        priority if (rows_reg == 13'd0) begin
            rows_eff = 13'd1;
        end else if (rows_reg > 13'(IMG_MAX)) begin
            rows_eff = 13'(IMG_MAX);
        end else begin
            rows_eff = rows_reg;
        end
        priority if (cols_reg == 13'd0) begin
            cols_eff = 13'd1;
        end else if (cols_reg > 13'(IMG_MAX)) begin
            cols_eff = 13'(IMG_MAX);
        end else begin
            cols_eff = cols_reg;
        end
    end

    assign pix_total = 25'(26'(rows_eff) * 26'(cols_eff));

    assign s_ready    = idle;
    assign in_acc     = s_valid && s_ready;
    assign sample_acc = in_acc && (s_cmd == CMD_SAMPLE);

    always_comb begin
        wr.we_w = in_acc && (s_cmd == CMD_WEIGHT);
        wr.we_b = in_acc && (s_cmd == CMD_BIAS) && (s_addr < 8'(CH_SLOTS));
        wr.we_x = sample_acc;
        wr.addr = s_addr;
        wr.slot = chan_slot;
        wr.data = s_value;
    end

    pwc_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .sample_acc (sample_acc),
        .n_in       (n_in),
        .n_out      (n_out),
        .pix_total  (pix_total),
        .stall      (stall),
        .idle       (idle),
        .chan_slot  (chan_slot),
        .issue      (issue)
    );

    pwc_mac u_mac (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .wr              (wr),
        .issue           (issue),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_out_channel   (m_out_channel),
        .m_result_value  (m_result_value),
        .m_last_of_pixel (m_last_of_pixel),
        .m_last_of_image (m_last_of_image),
        .stall           (stall)
    );

endmodule

`default_nettype wire

[verif/tb_pointwise_conv_1x1.sv]
module tb_pointwise_conv_1x1;
    import pwc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [3:0]         out_channel;
        logic signed [15:0] result_value;
        logic               last_of_pixel;
        logic               last_of_image;
    } conv_result_t;

    typedef enum logic {ROW_REQ, ROW_REG} row_kind_t;

    // A directed row is either one request or one register write. Rows with
    // a hand-typed result are also checked against that value.
    typedef struct packed {
        row_kind_t    kind;
        logic [1:0]   code;
        logic [7:0]   addr;
        logic [15:0]  data;
        logic         typed;
        conv_result_t want;
    } directed_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_cmd;
    logic [7:0]           s_addr;
    logic signed [15:0]   s_value;
    logic                 m_valid;
    logic                 m_ready;
    logic [3:0]           m_out_channel;
    logic signed [15:0]   m_result_value;
    logic                 m_last_of_pixel;
    logic                 m_last_of_image;

    // Shadow of the block: configuration, stores and counters.
    logic [4:0]           cfg_in_ch;
    logic [4:0]           cfg_out_ch;
    logic [12:0]          cfg_rows;
    logic [12:0]          cfg_cols;
    logic signed [15:0]   weights [256];
    logic signed [15:0]   biases [16];
    logic signed [15:0]   samples [16];
    logic [3:0]           chan_pos;
    logic [23:0]          pixel_pos;
    conv_result_t         pending_pixel_results [$];
    conv_result_t         seen_result;

    // What the stimulus side has loaded so far, so no unwritten entry is read.
    bit                   weight_loaded [256];
    bit                   bias_loaded [16];
    bit                   sender_eager = 1'b0;
    bit                   receiver_eager = 1'b0;
    bit                   failed = 1'b0;
    int                   cycle_count = 0;

    directed_row_t directed_rows [27] = '{
        '{ROW_REQ, CMD_WEIGHT, 8'h00, 16'h1000, 1'b0, '0},
        '{ROW_REQ, CMD_BIAS,   8'h00, 16'h0000, 1'b0, '0},
        '{ROW_REQ, CMD_SAMPLE, 8'h00, 16'h0100, 1'b1, '{4'd0, 16'sh0100, 1'b1, 1'b1}},
        '{ROW_REQ, CMD_SAMPLE, 8'hFF, 16'h7FFF, 1'b1, '{4'd0, 16'sh7FFF, 1'b1, 1'b1}},
        '{ROW_REQ, CMD_WEIGHT, 8'h00, 16'h7FFF, 1'b0, '0},
        '{ROW_REQ, CMD_SAMPLE, 8'hAA, 16'h7FFF, 1'b1, '{4'd0, 16'sh7FFF, 1'b1, 1'b1}},
        '{ROW_REQ, CMD_SAMPLE, 8'h55, 16'h8000, 1'b1, '{4'd0, -16'sd32768, 1'b1, 1'b1}},
        '{ROW_REQ, CMD_WEIGHT, 8'h00, 16'h0001, 1'b0, '0},
        '{ROW_REQ, CMD_SAMPLE, 8'h00, 16'h0800, 1'b1, '{4'd0, 16'sh0001, 1'b1, 1'b1}},
        '{ROW_REQ, CMD_SAMPLE, 8'h00, 16'hF800, 1'b1, '{4'd0, 16'sh0000, 1'b1, 1'b1}},
        '{ROW_REQ, CMD_BIAS,   8'hFF, 16'h7FFF, 1'b0, '0},
        '{ROW_REQ, CMD_UNUSED, 8'h55, 16'h7FFF, 1'b0, '0},
        '{ROW_REQ, CMD_SAMPLE, 8'h00, 16'h0800, 1'b1, '{4'd0, 16'sh0001, 1'b1, 1'b1}},
        '{ROW_REQ, CMD_BIAS,   8'h00, 16'h7FFF, 1'b0, '0},
        '{ROW_REQ, CMD_WEIGHT, 8'h00, 16'h0000, 1'b0, '0},
        '{ROW_REQ, CMD_SAMPLE, 8'h00, 16'h1234, 1'b1, '{4'd0, 16'sh0800, 1'b1, 1'b1}},
        '{ROW_REG, REG_ROWS,   8'h00, 16'd3,    1'b0, '0},
        '{ROW_REQ, CMD_SAMPLE, 8'h00, 16'h4321, 1'b0, '0},
        '{ROW_REG, REG_ROWS,   8'h00, 16'd1,    1'b0, '0},
        '{ROW_REQ, CMD_SAMPLE, 8'h00, 16'h0042, 1'b1, '{4'd0, 16'sh0800, 1'b1, 1'b1}},
        '{ROW_REQ, CMD_WEIGHT, 8'h01, 16'h0800, 1'b0, '0},
        '{ROW_REQ, CMD_WEIGHT, 8'h02, 16'hF000, 1'b0, '0},
        '{ROW_REG, REG_IN_CH,  8'h00, 16'd3,    1'b0, '0},
        '{ROW_REQ, CMD_SAMPLE, 8'h00, 16'h0300, 1'b0, '0},
        '{ROW_REQ, CMD_SAMPLE, 8'h00, 16'hFD00, 1'b0, '0},
        '{ROW_REG, REG_IN_CH,  8'h00, 16'd2,    1'b0, '0},
        '{ROW_REQ, CMD_SAMPLE, 8'h00, 16'h0777, 1'b0, '0}
    };

    pointwise_conv_1x1 i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_addr          (s_addr),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_channel   (m_out_channel),
        .m_result_value  (m_result_value),
        .m_last_of_pixel (m_last_of_pixel),
        .m_last_of_image (m_last_of_image)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int bounded_count(input int v, input int lim);
        if (v < 1) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic logic signed [15:0] draw_value();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2, 3: return 16'(int'($urandom_range(0, 1023)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // Updates the shadow for one accepted request and queues the results that a
    // completed pixel produces.
    task automatic conv_request(input logic [1:0] cmd, input logic [7:0] addr,
                                input logic signed [15:0] value);
        int           n_in;
        int           n_out;
        int           total;
        logic         img_last;
        longint       acc;
        longint       rounded;
        conv_result_t r;
        case (cmd)
            CMD_WEIGHT: weights[addr] = value;
            CMD_BIAS: begin
                if (addr < CH_SLOTS) biases[addr[3:0]] = value;
            end
            CMD_SAMPLE: begin
                n_in = bounded_count(cfg_in_ch, N_IN_LIM);
                n_out = bounded_count(cfg_out_ch, N_OUT_LIM);
                samples[chan_pos] = value;
                if (chan_pos + 1 < n_in) begin
                    chan_pos = chan_pos + 4'd1;
                end else begin
                    chan_pos = 4'd0;
                    total = bounded_count(cfg_rows, IMG_MAX) * bounded_count(cfg_cols, IMG_MAX);
                    img_last = (pixel_pos + 1 >= total);
                    pixel_pos = img_last ? 24'd0 : pixel_pos + 24'd1;
                    for (int co = 0; co < n_out; co++) begin
                        acc = longint'(biases[co]) * 256;
                        for (int ci = 0; ci < n_in; ci++)
                            acc += longint'(weights[co * 16 + ci]) * longint'(samples[ci]);
                        // Round half up, then clip to the signed 16-bit range.
                        rounded = (acc + 2048) >>> 12;
                        if (rounded > 32767) rounded = 32767;
                        else if (rounded < -32768) rounded = -32768;
                        r.out_channel = 4'(co);
                        r.result_value = 16'(rounded);
                        r.last_of_pixel = (co == n_out - 1);
                        r.last_of_image = (co == n_out - 1) && img_last;
                        pending_pixel_results.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic compare_result(input conv_result_t want, input conv_result_t got);
        if (got.out_channel !== want.out_channel) begin
            $error("out_channel: expected %0d, got %0d", want.out_channel, got.out_channel);
            failed = 1'b1;
        end
        if (got.result_value !== want.result_value) begin
            $error("result_value: expected %0d, got %0d", want.result_value, got.result_value);
            failed = 1'b1;
        end
        if (got.last_of_pixel !== want.last_of_pixel) begin
            $error("last_of_pixel: expected %0d, got %0d", want.last_of_pixel,
                   got.last_of_pixel);
            failed = 1'b1;
        end
        if (got.last_of_image !== want.last_of_image) begin
            $error("last_of_image: expected %0d, got %0d", want.last_of_image,
                   got.last_of_image);
            failed = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_in_ch = 5'd1;
            cfg_out_ch = 5'd1;
            cfg_rows = 13'd1;
            cfg_cols = 13'd1;
            chan_pos = 4'd0;
            pixel_pos = 24'd0;
            pending_pixel_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_IN_CH:  cfg_in_ch = pwdata[4:0];
                    REG_OUT_CH: cfg_out_ch = pwdata[4:0];
                    REG_ROWS:   cfg_rows = pwdata[12:0];
                    REG_COLS:   cfg_cols = pwdata[12:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) conv_request(s_cmd, s_addr, s_value);
            if (m_valid && m_ready) begin
                seen_result = '{m_out_channel, m_result_value, m_last_of_pixel,
                                m_last_of_image};
                if (pending_pixel_results.size() == 0) begin
                    $error("result on channel %0d with none expected", m_out_channel);
                    failed = 1'b1;
                end else begin
                    compare_result(pending_pixel_results.pop_front(), seen_result);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] cmd, input logic [7:0] addr,
                                input logic signed [15:0] value);
        int gap;
        if ($urandom_range(0, 15) == 0) sender_eager = !sender_eager;
        gap = sender_eager ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= cmd;
        s_addr <= addr;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        if (cmd == CMD_WEIGHT) weight_loaded[addr] = 1'b1;
        if (cmd == CMD_BIAS && addr < CH_SLOTS) bias_loaded[addr[3:0]] = 1'b1;
    endtask

    // Holds the input side until every queued result has arrived and the block
    // has had time to finish any request that gives no result.
    task automatic wait_results_done();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_pixel_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [1:0] index, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_phase(input logic [4:0] in_cfg, input logic [4:0] out_cfg,
                             input logic [12:0] rows_cfg, input logic [12:0] cols_cfg);
        int n_in;
        int n_out;
        int budget;
        wait_results_done();
        reg_write(REG_IN_CH, 32'(in_cfg));
        reg_write(REG_OUT_CH, 32'(out_cfg));
        reg_write(REG_ROWS, 32'(rows_cfg));
        reg_write(REG_COLS, 32'(cols_cfg));
        n_in = bounded_count(in_cfg, N_IN_LIM);
        n_out = bounded_count(out_cfg, N_OUT_LIM);
        // Every weight and bias a pixel of this shape reads must hold a value.
        for (int co = 0; co < n_out; co++) begin
            if (!bias_loaded[co] || $urandom_range(0, 3) == 0)
                send_request(CMD_BIAS, 8'(co), draw_value());
            for (int ci = 0; ci < n_in; ci++) begin
                if (!weight_loaded[co * 16 + ci] || $urandom_range(0, 3) == 0)
                    send_request(CMD_WEIGHT, 8'(co * 16 + ci), draw_value());
            end
        end
        budget = (n_in + 6 > 10) ? n_in + 6 : 10;
        repeat (budget) begin
            case ($urandom_range(0, 19))
                0: send_request(CMD_UNUSED, 8'($urandom), draw_value());
                1: send_request(CMD_WEIGHT, 8'($urandom), draw_value());
                2: send_request(CMD_BIAS, $urandom_range(0, 1) ? 8'($urandom_range(0, 15))
                                                                : 8'($urandom), draw_value());
                3: begin
                    wait_results_done();
                    send_request(CMD_SAMPLE, 8'($urandom), draw_value());
                end
                default: send_request(CMD_SAMPLE, 8'($urandom), draw_value());
            endcase
        end
    endtask

    initial begin
        int stall;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 15) == 0) receiver_eager = !receiver_eager;
            stall = receiver_eager ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        logic [4:0]  in_cfg;
        logic [4:0]  out_cfg;
        logic [12:0] rows_cfg;
        logic [12:0] cols_cfg;
        aresetn <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        s_valid <= 1'b0;
        s_cmd <= CMD_WEIGHT;
        s_addr <= '0;
        s_value <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_REG) begin
                wait_results_done();
                reg_write(directed_rows[i].code, 32'(directed_rows[i].data));
            end else begin
                send_request(directed_rows[i].code, directed_rows[i].addr,
                             directed_rows[i].data);
            end
            if (directed_rows[i].typed) begin
                wait_results_done();
                compare_result(directed_rows[i].want, seen_result);
            end
        end

        for (int p = 0; p < 5; p++) begin
            case (p)
                1: begin
                    in_cfg = 5'd31;
                    out_cfg = 5'd1;
                    rows_cfg = 13'd8191;
                    cols_cfg = 13'd4096;
                end
                2: begin
                    in_cfg = 5'd0;
                    out_cfg = 5'd0;
                    rows_cfg = 13'd0;
                    cols_cfg = 13'd0;
                end
                3: begin
                    in_cfg = 5'd1;
                    out_cfg = 5'd31;
                    rows_cfg = 13'd1;
                    cols_cfg = 13'd2;
                end
                default: begin
                    in_cfg = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(1, 16))
                                                         : 5'($urandom_range(1, 4));
                    out_cfg = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(1, 16))
                                                          : 5'($urandom_range(1, 4));
                    rows_cfg = 13'($urandom_range(1, 3));
                    cols_cfg = 13'($urandom_range(1, 3));
                end
            endcase
            run_phase(in_cfg, out_cfg, rows_cfg, cols_cfg);
        end

        wait_results_done();
        if (!failed) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
